// ----- design/keyframe_camera_interpolator_core_macros.svh -----
// assertion macros used by the keyframe camera interpolator datapath
`ifndef KEYFRAME_CAMERA_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_CAMERA_INTERPOLATOR_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define KFCI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe camera interpolator check failed");

// condition implies consequence in the next cycle
`define KFCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe camera interpolator check failed");

`endif

// ----- design/kfci_pkg.sv -----
// shared types, constants and helpers of the keyframe camera interpolator
`timescale 1ns / 1ps

package kfci_pkg;

    localparam int MAX_KEYS       = 256;
    localparam int EASE_STEPS     = 64;
    localparam int TAB_LEN        = EASE_STEPS + 1;
    localparam int NVALS          = 8;
    localparam int NCHAN          = 6;
    localparam int TAB_KEY_STRIDE = NCHAN * TAB_LEN;
    localparam int TAB_DEPTH      = MAX_KEYS * TAB_KEY_STRIDE;
    localparam int VAL_DEPTH      = MAX_KEYS * NVALS;

    // item function codes
    localparam logic [1:0] FUNC_KEY = 2'd0;
    localparam logic [1:0] FUNC_TAB = 2'd1;
    localparam logic [1:0] FUNC_ADV = 2'd2;
    localparam logic [1:0] FUNC_REW = 2'd3;

    // key field codes
    localparam logic [3:0] FSEL_TIME  = 4'd0;
    localparam logic [3:0] FSEL_POSX  = 4'd1;
    localparam logic [3:0] FSEL_FOV   = 4'd8;
    localparam logic [3:0] FSEL_FLAGS = 4'd9;

    // datapath commands
    localparam logic [4:0] OP_NOP      = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_RD_LAST  = 5'd2;
    localparam logic [4:0] OP_GOT_LAST = 5'd3;
    localparam logic [4:0] OP_GOT_LK   = 5'd4;
    localparam logic [4:0] OP_SCAN_RD  = 5'd5;
    localparam logic [4:0] OP_SCAN_CMP = 5'd6;
    localparam logic [4:0] OP_RD_T1    = 5'd7;
    localparam logic [4:0] OP_RD_T2    = 5'd8;
    localparam logic [4:0] OP_DECIDE   = 5'd9;
    localparam logic [4:0] OP_DIV      = 5'd10;
    localparam logic [4:0] OP_E_RD0    = 5'd11;
    localparam logic [4:0] OP_E_RD1    = 5'd12;
    localparam logic [4:0] OP_E_MUL    = 5'd13;
    localparam logic [4:0] OP_E_WW     = 5'd14;
    localparam logic [4:0] OP_E_BLEND  = 5'd15;
    localparam logic [4:0] OP_E_SUM    = 5'd16;
    localparam logic [4:0] OP_OUT      = 5'd17;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         key_index;
        logic [3:0]         field_select;
        logic [6:0]         table_index;
        logic signed [31:0] write_value;
        logic [15:0]        delta_frame;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] distance;
        logic signed [31:0] field_of_view;
        logic               finished;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic need_div;
        logic div_done;
        logic val_last;
        logic out_blocked;
    } t_sts;

    // easing channel used by each camera value
    function automatic logic [2:0] chan_of_value(input logic [2:0] j);
        logic [2:0] c;
        unique case (j)
            3'd0: c = 3'd0;
            3'd1: c = 3'd1;
            3'd2: c = 3'd2;
            3'd3, 3'd4, 3'd5: c = 3'd3;
            3'd6: c = 3'd4;
            3'd7: c = 3'd5;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- design/kfci_ctrl.sv -----
// controller state machine of the keyframe camera interpolator
`timescale 1ns / 1ps

module kfci_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_func,
    input  kfci_pkg::t_sts  i_sts,
    output kfci_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_LAST  = 5'd1;
    localparam logic [4:0] S_GOT_LAST = 5'd2;
    localparam logic [4:0] S_GOT_LK   = 5'd3;
    localparam logic [4:0] S_SCAN_RD  = 5'd4;
    localparam logic [4:0] S_SCAN_CMP = 5'd5;
    localparam logic [4:0] S_RD_T1    = 5'd6;
    localparam logic [4:0] S_RD_T2    = 5'd7;
    localparam logic [4:0] S_DECIDE   = 5'd8;
    localparam logic [4:0] S_DIV      = 5'd9;
    localparam logic [4:0] S_E_RD0    = 5'd10;
    localparam logic [4:0] S_E_RD1    = 5'd11;
    localparam logic [4:0] S_E_MUL    = 5'd12;
    localparam logic [4:0] S_E_WW     = 5'd13;
    localparam logic [4:0] S_E_BLEND  = 5'd14;
    localparam logic [4:0] S_E_SUM    = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = kfci_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = kfci_pkg::OP_LOAD;
                    if (i_func == kfci_pkg::FUNC_ADV) n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: begin
                o_cmd.op = kfci_pkg::OP_RD_LAST;
                n_state  = S_GOT_LAST;
            end
            S_GOT_LAST: begin
                o_cmd.op = kfci_pkg::OP_GOT_LAST;
                n_state  = S_GOT_LK;
            end
            S_GOT_LK: begin
                o_cmd.op = kfci_pkg::OP_GOT_LK;
                n_state  = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.op = kfci_pkg::OP_SCAN_RD;
                n_state  = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.op = kfci_pkg::OP_SCAN_CMP;
                n_state  = i_sts.scan_done ? S_RD_T1 : S_SCAN_RD;
            end
            S_RD_T1: begin
                o_cmd.op = kfci_pkg::OP_RD_T1;
                n_state  = S_RD_T2;
            end
            S_RD_T2: begin
                o_cmd.op = kfci_pkg::OP_RD_T2;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.op = kfci_pkg::OP_DECIDE;
                n_state  = i_sts.need_div ? S_DIV : S_E_RD0;
            end
            S_DIV: begin
                o_cmd.op = kfci_pkg::OP_DIV;
                if (i_sts.div_done) n_state = S_E_RD0;
            end
            S_E_RD0: begin
                o_cmd.op = kfci_pkg::OP_E_RD0;
                n_state  = S_E_RD1;
            end
            S_E_RD1: begin
                o_cmd.op = kfci_pkg::OP_E_RD1;
                n_state  = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.op = kfci_pkg::OP_E_MUL;
                n_state  = S_E_WW;
            end
            S_E_WW: begin
                o_cmd.op = kfci_pkg::OP_E_WW;
                n_state  = S_E_BLEND;
            end
            S_E_BLEND: begin
                o_cmd.op = kfci_pkg::OP_E_BLEND;
                n_state  = S_E_SUM;
            end
            S_E_SUM: begin
                o_cmd.op = kfci_pkg::OP_E_SUM;
                n_state  = i_sts.val_last ? S_DONE : S_E_RD0;
            end
            S_DONE: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.op = kfci_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/kfci_dp.sv -----
// datapath of the keyframe camera interpolator: key stores, search, divider, blend
`timescale 1ns / 1ps
`include "keyframe_camera_interpolator_core_macros.svh"

module kfci_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kfci_pkg::t_in   i_in,
    input  logic            i_cfg_we,
    input  logic [8:0]      i_cfg_wdata,
    input  kfci_pkg::t_cmd  i_cmd,
    output kfci_pkg::t_sts  o_sts,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output kfci_pkg::t_out  o_out
);

    // key stores
    logic [23:0] r_time_mem [0:kfci_pkg::MAX_KEYS-1];
    logic [31:0] r_val_mem  [0:kfci_pkg::VAL_DEPTH-1];
    logic [5:0]  r_flag_mem [0:kfci_pkg::MAX_KEYS-1];
    logic [16:0] r_tab_mem  [0:kfci_pkg::TAB_DEPTH-1];

    logic [23:0] r_time_q;
    logic [31:0] r_val_q;
    logic [5:0]  r_flag_q;
    logic [16:0] r_tab_q;

    // control state
    logic [8:0]  r_key_count;
    logic [23:0] r_cur;
    logic [7:0]  r_last_key;
    logic        r_out_valid;

    // working registers
    logic [23:0] r_last, r_frame, r_t1, r_rem, r_div;
    logic [15:0] r_delta, r_w;
    logic [7:0]  r_i, r_hi, r_k1, r_k2, r_ka, r_kb;
    logic        r_hold;
    logic [3:0]  r_dcnt;
    logic [2:0]  r_j;
    logic [5:0]  r_flags;
    logic [16:0] r_tab0, r_ww;
    logic [31:0] r_va, r_vb;
    logic [33:0] r_m0, r_m1;
    logic signed [50:0] r_prod;
    logic [31:0] r_res [0:kfci_pkg::NVALS-1];
    kfci_pkg::t_out r_out;

    logic [4:0]  op;
    logic [7:0]  key_m1;
    logic        lk_in;
    logic [2:0]  ch;
    logic [5:0]  idx;
    logic [15:0] frac;
    logic [16:0] tab_base, tab_raddr, tab_waddr;
    logic [7:0]  time_raddr;
    logic [10:0] val_raddr, val_waddr;
    logic        wr_time, wr_val, wr_flag, wr_tab, is_load;
    logic [23:0] t2;
    logic        hold1, hold2, blend;
    logic [24:0] rem2;
    logic        ge;
    logic [7:0]  k2n, k1n;
    logic        hit;
    logic [34:0] msum;
    logic [16:0] n_ww;
    logic signed [32:0] diff;
    logic signed [17:0] ww_s;
    logic signed [50:0] n_prod;
    logic signed [51:0] psum;
    logic signed [35:0] rsh;
    logic [31:0] n_res;
    logic [24:0] nxt;
    logic        fin;
    logic [8:0]  cfg_clamped;

    assign op      = i_cmd.op;
    assign key_m1  = 8'(r_key_count - 9'd1);
    assign lk_in   = ({1'b0, r_last_key} < r_key_count);
    assign ch      = kfci_pkg::chan_of_value(r_j);
    assign idx     = r_w[15:10];
    assign frac    = {r_w[9:0], 6'b000000};

    // load decode
    assign is_load = (op == kfci_pkg::OP_LOAD);
    assign wr_time = is_load && (i_in.func == kfci_pkg::FUNC_KEY)
                     && (i_in.field_select == kfci_pkg::FSEL_TIME);
    assign wr_val  = is_load && (i_in.func == kfci_pkg::FUNC_KEY)
                     && (i_in.field_select >= kfci_pkg::FSEL_POSX)
                     && (i_in.field_select <= kfci_pkg::FSEL_FOV);
    assign wr_flag = is_load && (i_in.func == kfci_pkg::FUNC_KEY)
                     && (i_in.field_select == kfci_pkg::FSEL_FLAGS);
    assign wr_tab  = is_load && (i_in.func == kfci_pkg::FUNC_TAB)
                     && (i_in.field_select < 4'(kfci_pkg::NCHAN))
                     && (i_in.table_index <= 7'(kfci_pkg::EASE_STEPS));
    assign val_waddr = {i_in.key_index, 3'(i_in.field_select - kfci_pkg::FSEL_POSX)};
    assign tab_waddr = 17'(i_in.key_index) * 17'(kfci_pkg::TAB_KEY_STRIDE)
                     + 17'(i_in.field_select[2:0]) * 17'(kfci_pkg::TAB_LEN)
                     + 17'(i_in.table_index);

    // read addresses
    assign tab_base  = 17'(r_k2) * 17'(kfci_pkg::TAB_KEY_STRIDE)
                     + 17'(ch) * 17'(kfci_pkg::TAB_LEN);
    assign tab_raddr = tab_base + 17'(idx) + ((op == kfci_pkg::OP_E_RD1) ? 17'd1 : 17'd0);
    assign val_raddr = {((op == kfci_pkg::OP_E_RD1) ? r_kb : r_ka), r_j};

    always_comb begin
        unique case (op)
            kfci_pkg::OP_RD_LAST:  time_raddr = key_m1;
            kfci_pkg::OP_GOT_LAST: time_raddr = r_last_key;
            kfci_pkg::OP_RD_T1:    time_raddr = r_k1;
            kfci_pkg::OP_RD_T2:    time_raddr = r_k2;
            default:               time_raddr = r_i;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (wr_time) r_time_mem[i_in.key_index] <= i_in.write_value[23:0];
        if (wr_val)  r_val_mem[val_waddr] <= i_in.write_value;
        if (wr_flag) r_flag_mem[i_in.key_index] <= i_in.write_value[5:0];
        if (wr_tab)  r_tab_mem[tab_waddr] <= i_in.write_value[16:0];
        r_time_q <= r_time_mem[time_raddr];
        r_val_q  <= r_val_mem[val_raddr];
        r_flag_q <= r_flag_mem[r_k2];
        r_tab_q  <= r_tab_mem[tab_raddr];
    end

    // search result
    assign hit = (r_frame <= r_time_q);
    assign k2n = hit ? r_i : 8'd0;
    assign k1n = (k2n <= 8'd1) ? 8'd0 : k2n - 8'd1;

    // hold or blend decision
    assign t2    = r_time_q;
    assign hold1 = (r_t1 == t2) || (r_frame <= r_t1)
                   || ((r_frame < t2) && ((t2 - r_t1) <= 24'd256));
    assign hold2 = !hold1 && (r_frame >= t2);
    assign blend = !hold1 && !hold2;

    // restoring divider step
    assign rem2 = {r_rem, 1'b0};
    assign ge   = (rem2 >= {1'b0, r_div});

    // easing weight and blend arithmetic
    assign msum   = {1'b0, r_m0} + {1'b0, r_m1} + 35'd32768;
    always_comb begin
        priority if (r_hold)     n_ww = 17'd0;
        else if (r_flags[ch])    n_ww = {1'b0, r_w};
        else                     n_ww = msum[32:16];
    end
    assign diff   = $signed({r_vb[31], r_vb}) - $signed({r_va[31], r_va});
    assign ww_s   = $signed({1'b0, r_ww});
    assign n_prod = diff * ww_s;
    assign psum   = $signed({{4{r_va[31]}}, r_va, 16'h0000})
                  + $signed({r_prod[50], r_prod}) + 52'sd32768;
    assign rsh    = psum[51:16];
    assign n_res  = ((rsh[35:31] == 5'b00000) || (rsh[35:31] == 5'b11111))
                  ? rsh[31:0] : (rsh[35] ? 32'h8000_0000 : 32'h7fff_ffff);

    // frame advance
    assign nxt = {1'b0, r_cur} + 25'(r_delta);
    assign fin = (nxt >= {1'b0, r_last});

    assign cfg_clamped = (i_cfg_wdata == 9'd0) ? 9'd1
                       : ((i_cfg_wdata > 9'(kfci_pkg::MAX_KEYS))
                          ? 9'(kfci_pkg::MAX_KEYS) : i_cfg_wdata);

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 9'd1;
            r_cur       <= 24'd0;
            r_last_key  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_key_count <= cfg_clamped;
            if (is_load && (i_in.func == kfci_pkg::FUNC_REW)) begin
                r_cur      <= 24'd0;
                r_last_key <= 8'd0;
            end
            if ((op == kfci_pkg::OP_SCAN_CMP) && (hit || (r_i == r_hi))) r_last_key <= k1n;
            // a new result replaces one that leaves in the same cycle
            if (op == kfci_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
                r_cur       <= fin ? r_last : nxt[23:0];
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (op)
            kfci_pkg::OP_LOAD: r_delta <= i_in.delta_frame;
            kfci_pkg::OP_GOT_LAST: begin
                r_last  <= r_time_q;
                r_frame <= (r_cur < r_time_q) ? r_cur : r_time_q;
            end
            kfci_pkg::OP_GOT_LK: begin
                if (lk_in && (r_frame >= r_time_q)) begin
                    r_i  <= r_last_key;
                    r_hi <= key_m1;
                end else begin
                    r_i  <= 8'd0;
                    r_hi <= lk_in ? r_last_key : key_m1;
                end
            end
            kfci_pkg::OP_SCAN_CMP: begin
                if (hit || (r_i == r_hi)) begin
                    r_k2 <= k2n;
                    r_k1 <= k1n;
                end else begin
                    r_i <= r_i + 8'd1;
                end
            end
            kfci_pkg::OP_RD_T2: r_t1 <= r_time_q;
            kfci_pkg::OP_DECIDE: begin
                r_hold  <= !blend;
                r_ka    <= hold2 ? r_k2 : r_k1;
                r_kb    <= hold1 ? r_k1 : r_k2;
                r_flags <= r_flag_q;
                r_rem   <= r_frame - r_t1;
                r_div   <= t2 - r_t1;
                r_dcnt  <= 4'd0;
                r_w     <= 16'd0;
                r_j     <= 3'd0;
            end
            kfci_pkg::OP_DIV: begin
                r_rem  <= ge ? 24'(rem2 - {1'b0, r_div}) : rem2[23:0];
                r_w    <= {r_w[14:0], ge};
                r_dcnt <= r_dcnt + 4'd1;
            end
            kfci_pkg::OP_E_RD1: begin
                r_tab0 <= r_tab_q;
                r_va   <= r_val_q;
            end
            kfci_pkg::OP_E_MUL: begin
                r_m0 <= 34'(r_tab0) * 34'(17'h10000 - {1'b0, frac});
                r_m1 <= 34'(r_tab_q) * 34'(frac);
                r_vb <= r_val_q;
            end
            kfci_pkg::OP_E_WW:    r_ww <= n_ww;
            kfci_pkg::OP_E_BLEND: r_prod <= n_prod;
            kfci_pkg::OP_E_SUM: begin
                r_res[r_j] <= n_res;
                r_j        <= r_j + 3'd1;
            end
            kfci_pkg::OP_OUT: begin
                r_out.pos_x         <= r_res[0];
                r_out.pos_y         <= r_res[1];
                r_out.pos_z         <= r_res[2];
                r_out.angle_x       <= r_res[3];
                r_out.angle_y       <= r_res[4];
                r_out.angle_z       <= r_res[5];
                r_out.distance      <= r_res[6];
                r_out.field_of_view <= r_res[7];
                r_out.finished      <= fin;
            end
            default: ;
        endcase
    end

    assign o_sts.scan_done   = hit || (r_i == r_hi);
    assign o_sts.need_div    = blend;
    assign o_sts.div_done    = (r_dcnt == 4'd15);
    assign o_sts.val_last    = (r_j == 3'd7);
    assign o_sts.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    // checks
    `KFCI_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, op == kfci_pkg::OP_OUT, r_out_valid)
    `KFCI_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, op == kfci_pkg::OP_SCAN_CMP, r_i <= r_hi)
    `KFCI_ASSERT_NOW(a_div_rem, i_clk, i_rst_n, op == kfci_pkg::OP_DIV, r_rem < r_div)
    `KFCI_ASSERT_NEXT(a_frame_clamp, i_clk, i_rst_n, op == kfci_pkg::OP_OUT, r_cur <= r_last)

endmodule

// ----- design/keyframe_camera_interpolator_core.sv -----
// top level of the keyframe camera interpolator
`timescale 1ns / 1ps

// Keyframe camera interpolator. Key-field, easing-entry and rewind items are taken
// while the block is idle and give no result. An advance item gives one result,
// found as follows: the search reads the key time store one key at a time, with a
// read step and a compare step per key, a restoring divider makes one weight bit
// per cycle when two keys are blended, and the eight camera values go one after
// another through a shared easing and blend path of read, multiply, weight, blend
// and sum steps. The result waits in an output register; loads are taken meanwhile.
// The key_count register must be written only while the block is idle.
module keyframe_camera_interpolator_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  kfci_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output kfci_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [8:0]      i_cfg_wdata
);

    kfci_pkg::t_cmd cmd;
    kfci_pkg::t_sts sts;

    // sequencer
    kfci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // stores and arithmetic
    kfci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the keyframe camera interpolator core
`timescale 1ns / 1ps

module tb;
    import kfci_pkg::*;

    localparam int          LIMIT_CYCLES = 3000000;
    localparam int          TAB_KEYS     = 7;     // keys with one loaded easing channel each
    localparam int          FULL_KEYS    = 17;    // keys with every field written
    localparam logic [23:0] TAIL_TIME    = 24'h0F0000;
    localparam int          ITEMS_TOTAL  = 1850;

    // camera predictor plus queue of expected camera results
    class camera_scoreboard;
        bit [23:0]   ktime[MAX_KEYS];
        bit [31:0]   kval[MAX_KEYS][NVALS];
        bit [5:0]    kflag[MAX_KEYS];
        bit [16:0]   ktab[MAX_KEYS][NCHAN][TAB_LEN];
        bit [23:0]   frame_now;
        bit [7:0]    last_k;
        int unsigned nkeys = 1;
        t_out        cam_q[$];
        int          errors;
        int          results;

        function void set_count(bit [8:0] v);
            nkeys = (v == 0) ? 1 : ((v > MAX_KEYS) ? MAX_KEYS : v);
        endfunction

        function bit [31:0] blend(bit [31:0] ab, bit [31:0] bb, bit [31:0] ww);
            longint a;
            longint b;
            longint p;
            longint r;
            a = longint'($signed(ab));
            b = longint'($signed(bb));
            p = a * 65536 + (b - a) * longint'(ww) + 32768;
            r = p >>> 16;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function bit [31:0] eased(int k, int ch, bit [31:0] w);
            longint unsigned p;
            longint unsigned f;
            longint unsigned t0;
            longint unsigned t1;
            longint unsigned s;
            int idx;
            p = longint'(w) * EASE_STEPS;
            idx = int'(p >> 16);
            f = p & 64'hFFFF;
            if (idx >= EASE_STEPS) idx = EASE_STEPS - 1;
            t0 = ktab[k][ch][idx];
            t1 = ktab[k][ch][idx + 1];
            s = (t0 * (65536 - f) + t1 * f + 32768) >> 16;
            return s[31:0];
        endfunction

        // camera at the current frame, then step the frame
        function t_out camera_step(bit [15:0] delta);
            t_out        e;
            bit [31:0]   r[NVALS];
            bit [23:0]   lastt;
            bit [23:0]   frame;
            bit [23:0]   t1;
            bit [23:0]   t2;
            bit [31:0]   w;
            bit [31:0]   ww;
            bit [31:0]   nxt;
            longint unsigned q;
            int          lo, hi, k1, k2, ch;
            bit          found;
            lastt = ktime[nkeys - 1];
            frame = (frame_now < lastt) ? frame_now : lastt;
            if (last_k < nkeys && frame >= ktime[last_k]) begin
                lo = last_k;
                hi = nkeys - 1;
            end else begin
                lo = 0;
                hi = (last_k < nkeys) ? last_k : nkeys - 1;
            end
            k2 = 0;
            found = 0;
            for (int i = lo; i <= hi; i++) begin
                if (!found && frame <= ktime[i]) begin
                    k2 = i;
                    found = 1;
                end
            end
            k1 = (k2 <= 1) ? 0 : k2 - 1;
            last_k = k1;
            t1 = ktime[k1];
            t2 = ktime[k2];
            if (t1 == t2 || frame <= t1 || (frame < t2 && t2 - t1 <= 256)) begin
                for (int j = 0; j < NVALS; j++) r[j] = kval[k1][j];
            end else if (frame >= t2) begin
                for (int j = 0; j < NVALS; j++) r[j] = kval[k2][j];
            end else begin
                q = (longint'(frame - t1) << 16) / longint'(t2 - t1);
                w = q[31:0];
                for (int j = 0; j < NVALS; j++) begin
                    ch = chan_of_value(j[2:0]);
                    ww = kflag[k2][ch] ? w : eased(k2, ch, w);
                    r[j] = blend(kval[k1][j], kval[k2][j], ww);
                end
            end
            e.pos_x = r[0];
            e.pos_y = r[1];
            e.pos_z = r[2];
            e.angle_x = r[3];
            e.angle_y = r[4];
            e.angle_z = r[5];
            e.distance = r[6];
            e.field_of_view = r[7];
            nxt = 32'(frame_now) + 32'(delta);
            if (nxt >= 32'(lastt)) begin
                frame_now = lastt;
                e.finished = 1'b1;
            end else begin
                frame_now = nxt[23:0];
                e.finished = 1'b0;
            end
            return e;
        endfunction

        function void note_input(t_in it);
            case (it.func)
                FUNC_KEY: begin
                    if (it.field_select == FSEL_TIME)
                        ktime[it.key_index] = it.write_value[23:0];
                    else if (it.field_select >= FSEL_POSX && it.field_select <= FSEL_FOV)
                        kval[it.key_index][it.field_select - FSEL_POSX] = it.write_value;
                    else if (it.field_select == FSEL_FLAGS)
                        kflag[it.key_index] = it.write_value[5:0];
                end
                FUNC_TAB: begin
                    if (it.field_select < NCHAN && it.table_index <= EASE_STEPS)
                        ktab[it.key_index][it.field_select][it.table_index] =
                            it.write_value[16:0];
                end
                FUNC_REW: begin
                    frame_now = 0;
                    last_k = 0;
                end
                default: cam_q.push_back(camera_step(it.delta_frame));
            endcase
        endfunction

        function void cmp(string name, bit [31:0] e, bit [31:0] a);
            if (e !== a) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d %s: expected %h got %h",
                             results, name, e, a);
            end
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (cam_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected camera result %h", got);
                return;
            end
            e = cam_q.pop_front();
            cmp("pos_x", e.pos_x, got.pos_x);
            cmp("pos_y", e.pos_y, got.pos_y);
            cmp("pos_z", e.pos_z, got.pos_z);
            cmp("angle_x", e.angle_x, got.angle_x);
            cmp("angle_y", e.angle_y, got.angle_y);
            cmp("angle_z", e.angle_z, got.angle_z);
            cmp("distance", e.distance, got.distance);
            cmp("field_of_view", e.field_of_view, got.field_of_view);
            cmp("finished", 32'(e.finished), 32'(got.finished));
            results++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_item;
    logic        out_valid;
    logic        out_stall;
    t_out        out_item;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;

    camera_scoreboard sb;
    int          cycles;
    int          burst_left;
    int          sent;
    int          phases;

    keyframe_camera_interpolator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check transfers, stall in changing patterns
    always @(posedge clk) begin
        int phase;
        phase = (cycles / 300) % 4;
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
        case (phase)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ((cycles % 23) < 9);
            default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    // one input transfer, with random bursts and gaps
    task automatic send(t_in it);
        int gap;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        sent++;
    endtask

    function automatic t_in make_item(logic [1:0] f, logic [7:0] k, logic [3:0] fs,
                                      logic [6:0] ti, logic [31:0] wv, logic [15:0] d);
        t_in it;
        it.func = f;
        it.key_index = k;
        it.field_select = fs;
        it.table_index = ti;
        it.write_value = wv;
        it.delta_frame = d;
        return it;
    endfunction

    function automatic logic [31:0] rnd32();
        return $urandom();
    endfunction

    // easing channel whose table is loaded for a key
    function automatic int tab_chan(int k);
        return k % NCHAN;
    endfunction

    // only the loaded easing channel of a key may be eased
    function automatic logic [31:0] flag_value(int k, logic [31:0] v);
        return (k < TAB_KEYS) ? (v | (32'h3F & ~(32'h1 << tab_chan(k)))) : (v | 32'h3F);
    endfunction

    task automatic key_write(int k, logic [3:0] fs, logic [31:0] v);
        send(make_item(FUNC_KEY, k[7:0], fs, 7'($urandom_range(0, 127)), v,
                       16'($urandom())));
    endtask

    task automatic advance(logic [15:0] d);
        send(make_item(FUNC_ADV, 8'($urandom()), 4'($urandom()),
                       7'($urandom_range(0, 127)), rnd32(), d));
    endtask

    task automatic rewind();
        send(make_item(FUNC_REW, 8'($urandom()), 4'($urandom()),
                       7'($urandom_range(0, 127)), rnd32(), 16'($urandom())));
    endtask

    // let everything drain before touching the register
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.cam_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_key_count(logic [8:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_count(v);
        @(posedge clk);
    endtask

    function automatic logic [31:0] value_pick();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            default: return rnd32();
        endcase
    endfunction

    // non-descending key times with repeated times, cuts and normal spans
    task automatic load_keys(int n, int start_t);
        int t;
        t = start_t;
        for (int k = 0; k < n; k++) begin
            key_write(k, FSEL_TIME, t);
            for (int j = 0; j < NVALS; j++) key_write(k, 4'(FSEL_POSX + j), value_pick());
            key_write(k, FSEL_FLAGS, flag_value(k, rnd32()));
            case ($urandom_range(0, 7))
                0: t += 0;
                1: t += $urandom_range(1, 256);
                default: t += $urandom_range(257, 4000);
            endcase
            if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        end
    endtask

    // random writes that never expose an unwritten store entry
    task automatic noise_item();
        int k;
        k = $urandom_range(0, 255);
        case ($urandom_range(0, 5))
            0: key_write(k, 4'($urandom_range(10, 15)), rnd32());
            1: key_write(k, FSEL_FLAGS, flag_value(k, rnd32()));
            2: key_write(k, 4'($urandom_range(1, 8)), value_pick());
            3: key_write(int'($urandom_range(0, 15)), FSEL_TIME, rnd32());
            4: send(make_item(FUNC_TAB, 8'($urandom_range(0, TAB_KEYS - 1)),
                              4'($urandom_range(0, 5)), 7'($urandom_range(0, EASE_STEPS)),
                              rnd32(), 16'($urandom())));
            default: send(make_item(FUNC_TAB, k[7:0], 4'($urandom_range(6, 15)),
                                    7'($urandom_range(EASE_STEPS + 1, 127)), rnd32(),
                                    16'($urandom())));
        endcase
    endtask

    // stimulus
    initial begin
        int n;
        int span;
        int cnt;
        int d;
        int sel;
        sb = new();
        cycles <= 0;
        burst_left = 0;
        sent = 0;
        phases = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        out_stall <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the leading keys, park the rest at one late time, load easing tables
        load_keys(FULL_KEYS, 0);
        key_write(FULL_KEYS - 1, FSEL_TIME, 32'(TAIL_TIME));
        for (int k = FULL_KEYS; k < MAX_KEYS; k++) key_write(k, FSEL_TIME, 32'(TAIL_TIME));
        for (int k = 0; k < TAB_KEYS; k++)
            for (int e = 0; e <= EASE_STEPS; e++)
                send(make_item(FUNC_TAB, 8'(k), 4'(tab_chan(k)), 7'(e),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17'h1FFFF)
                                   : 32'(e * 1024 + $urandom_range(0, 2047)),
                               16'($urandom())));

        // directed: single key, equal times, cut, blend, extremes, rewind, bad addresses
        advance(16'h0000);
        wait_idle();
        set_key_count(9'd4);
        key_write(0, FSEL_TIME, 0);
        key_write(1, FSEL_TIME, 0);
        key_write(2, FSEL_TIME, 200);
        key_write(3, FSEL_TIME, 2000);
        key_write(2, FSEL_POSX, 32'h8000_0000);
        key_write(3, FSEL_POSX, 32'h7FFF_FFFF);
        key_write(3, FSEL_FLAGS, flag_value(3, 32'h0000_0015));
        advance(16'd100);
        advance(16'd150);
        advance(16'd300);
        advance(16'd0);
        advance(16'hFFFF);
        advance(16'd1);
        rewind();
        advance(16'd600);
        advance(16'd700);
        key_write(5, 4'd15, rnd32());
        send(make_item(FUNC_TAB, 8'd255, 4'd7, 7'd127, rnd32(), 16'hFFFF));
        send(make_item(FUNC_TAB, 8'd3, 4'd2, 7'd65, rnd32(), 16'h0));
        advance(16'd10);
        wait_idle();

        // random phases over several key counts
        while (sent < ITEMS_TOTAL) begin
            if (phases % 5 == 1) n = MAX_KEYS;
            else if (phases % 5 == 3) n = 1;
            else n = $urandom_range(2, FULL_KEYS - 1);
            if (phases % 7 == 3) set_key_count((n == MAX_KEYS) ? 9'h1FF : 9'd0);
            else set_key_count(n[8:0]);
            if (n < FULL_KEYS && $urandom_range(0, 2) == 0)
                load_keys(n, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000));
            span = sb.ktime[sb.nkeys - 1];
            cnt = $urandom_range(20, 60);
            for (int i = 0; i < cnt; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    case ($urandom_range(0, 19))
                        0: d = 0;
                        1: d = 16'hFFFF;
                        default: d = $urandom_range(0, span / 8 + 1);
                    endcase
                    if (d > 16'hFFFF) d = 16'hFFFF;
                    advance(d[15:0]);
                end else if (sel < 88) begin
                    rewind();
                end else begin
                    noise_item();
                end
            end
            wait_idle();
            phases++;
        end

        wait_idle();
        $display("tb: %0d items sent, %0d camera results checked over %0d random phases",
                 sent, sb.results, phases);
        $display("tb: key counts from one to full, cuts, holds, eased and linear blends");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", sb.errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
